// ===== hdl/plil_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the positional insert/erase list.
// Depends on nothing; every other file of the block uses it.
package plil_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int VAL_W = 32;
  localparam int POS_W = 8;
  localparam int LEN_W = 5;
  localparam int OP_W = 2;
  localparam int ST_W = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_ERASE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [LEN_W-1:0] length;
    logic [ST_W-1:0] status;
    logic last;
  } res_t;

endpackage

// ===== hdl/plil_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input transfers, drops unused opcodes and queues commands.
// Depends on plil_pkg.
module plil_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [plil_pkg::OP_W-1:0] opcode,
  input  logic signed [plil_pkg::VAL_W-1:0] item_value,
  input  logic [plil_pkg::POS_W-1:0] slot_position,
  output logic cmd_valid,
  output plil_pkg::cmd_t cmd,
  input  logic cmd_take
);

  plil_pkg::cmd_t q [2];
  logic wp;
  logic rp;
  logic [1:0] cnt;
  logic enq;

  assign full = (cnt == 2'd2);
  assign enq = push && !full && (opcode != plil_pkg::OP_NONE);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rp];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wp] <= '{op: opcode, value: item_value, pos: slot_position};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (enq) begin
        wp <= !wp;
      end
      if (cmd_take) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(enq) - 2'(cmd_take);
    end
  end

endmodule

// ===== hdl/plil_back.sv =====
`timescale 1ns / 1ps
// Back end: holds the cells, carries out insert, erase and read out, and
// queues the results. Depends on plil_pkg.
module plil_back (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  plil_pkg::cmd_t cmd,
  output logic cmd_take,
  output logic empty,
  input  logic pop,
  output plil_pkg::res_t res
);

  logic signed [plil_pkg::VAL_W-1:0] cells [plil_pkg::CAPACITY];
  logic signed [plil_pkg::VAL_W-1:0] up [plil_pkg::CAPACITY];
  logic signed [plil_pkg::VAL_W-1:0] dn [plil_pkg::CAPACITY];
  logic [plil_pkg::CNT_W-1:0] count;
  logic [plil_pkg::CNT_W-1:0] count_next;
  logic rd_active;
  logic rd_active_next;
  logic [plil_pkg::IDX_W-1:0] rd_idx;
  logic [plil_pkg::IDX_W-1:0] rd_idx_next;
  logic [8:0] pos9;
  logic [8:0] cnt9;
  logic [8:0] ins_pos;
  logic [8:0] era_pos;
  logic do_ins;
  logic do_era;
  logic room;
  logic emit;
  plil_pkg::res_t emit_res;
  logic rd_last;

  plil_pkg::res_t rq [2];
  logic rwp;
  logic rrp;
  logic [1:0] rcnt;
  logic deq;

  assign room = (rcnt != 2'd2);
  assign cmd_take = cmd_valid && !rd_active && room;
  assign pos9 = {1'b0, cmd.pos};
  assign cnt9 = 9'(count);
  assign ins_pos = (pos9 > cnt9) ? cnt9 : pos9;
  assign era_pos = (pos9 > cnt9 - 9'd1) ? cnt9 - 9'd1 : pos9;
  assign rd_last = (plil_pkg::CNT_W'(rd_idx) + plil_pkg::CNT_W'(1) == count);

  always_comb begin
    up[0] = cells[0];
    for (int i = 1; i < plil_pkg::CAPACITY; i++) begin
      up[i] = cells[i-1];
    end
    for (int i = 0; i < plil_pkg::CAPACITY - 1; i++) begin
      dn[i] = cells[i+1];
    end
    dn[plil_pkg::CAPACITY-1] = cells[plil_pkg::CAPACITY-1];
  end

  always_comb begin
    emit = 1'b0;
    emit_res = '{value: '0, length: plil_pkg::LEN_W'(count), status: plil_pkg::ST_OK,
                 last: 1'b1};
    do_ins = 1'b0;
    do_era = 1'b0;
    count_next = count;
    rd_active_next = rd_active;
    rd_idx_next = rd_idx;
    if (rd_active) begin
      if (room) begin
        emit = 1'b1;
        emit_res.value = cells[rd_idx];
        emit_res.last = rd_last;
        rd_idx_next = rd_idx + plil_pkg::IDX_W'(1);
        if (rd_last) begin
          rd_active_next = 1'b0;
        end
      end
    end else if (cmd_take) begin
      case (cmd.op)
        plil_pkg::OP_INSERT: begin
          emit = 1'b1;
          if (count >= plil_pkg::CNT_W'(plil_pkg::CAPACITY)) begin
            emit_res.status = plil_pkg::ST_FULL;
          end else begin
            do_ins = 1'b1;
            count_next = count + plil_pkg::CNT_W'(1);
            emit_res.length = plil_pkg::LEN_W'(count_next);
          end
        end
        plil_pkg::OP_ERASE: begin
          emit = 1'b1;
          if (count == '0) begin
            emit_res.status = plil_pkg::ST_EMPTY;
          end else begin
            do_era = 1'b1;
            count_next = count - plil_pkg::CNT_W'(1);
            emit_res.length = plil_pkg::LEN_W'(count_next);
          end
        end
        plil_pkg::OP_READ: begin
          if (count == '0) begin
            emit = 1'b1;
            emit_res.status = plil_pkg::ST_EMPTY;
          end else begin
            rd_active_next = 1'b1;
            rd_idx_next = '0;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < plil_pkg::CAPACITY; i++) begin
      if (do_ins) begin
        if (9'(i) == ins_pos) begin
          cells[i] <= cmd.value;
        end else if (9'(i) > ins_pos) begin
          cells[i] <= up[i];
        end
      end else if (do_era) begin
        if (9'(i) >= era_pos) begin
          cells[i] <= dn[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rd_active <= 1'b0;
      rd_idx <= '0;
    end else begin
      count <= count_next;
      rd_active <= rd_active_next;
      rd_idx <= rd_idx_next;
    end
  end

  assign empty = (rcnt == 2'd0);
  assign deq = pop && !empty;
  assign res = rq[rrp];

  always_ff @(posedge clk) begin
    if (emit) begin
      rq[rwp] <= emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rwp <= 1'b0;
      rrp <= 1'b0;
      rcnt <= 2'd0;
    end else begin
      if (emit) begin
        rwp <= !rwp;
      end
      if (deq) begin
        rrp <= !rrp;
      end
      rcnt <= rcnt + 2'(emit) - 2'(deq);
    end
  end

endmodule

// ===== hdl/positional_insert_erase_list_core.sv =====
`timescale 1ns / 1ps
// Top level of the positional insert/erase list: front end, back end and checks.
// Depends on plil_pkg, plil_front and plil_back.

// An ordered list of up to 16 signed 32-bit values. Insert and erase are each
// carried out by the back end, which shifts all cells past the position at
// once, and each give one result. A read out is taken and then gives one
// result per stored entry, one per cycle while the result queue has room, and
// one result on an empty list. The back end's single result write per cycle sets
// this rate. A two-entry command queue lets the input side keep transferring
// while the back end works, and a two-entry result queue holds results until
// they are popped.
module positional_insert_erase_list_core (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [plil_pkg::OP_W-1:0] opcode,
  input  logic signed [plil_pkg::VAL_W-1:0] item_value,
  input  logic [plil_pkg::POS_W-1:0] slot_position,
  output logic empty,
  input  logic pop,
  output logic signed [plil_pkg::VAL_W-1:0] entry_value,
  output logic [plil_pkg::LEN_W-1:0] list_length,
  output logic [plil_pkg::ST_W-1:0] op_status,
  output logic last_item
);

  logic cmd_valid;
  logic cmd_take;
  plil_pkg::cmd_t cmd;
  plil_pkg::res_t res;

  plil_front u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .opcode(opcode),
    .item_value(item_value),
    .slot_position(slot_position),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_take(cmd_take)
  );

  plil_back u_back (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_take(cmd_take),
    .empty(empty),
    .pop(pop),
    .res(res)
  );

  assign entry_value = res.value;
  assign list_length = res.length;
  assign op_status = res.status;
  assign last_item = res.last;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (list_length <= plil_pkg::LEN_W'(plil_pkg::CAPACITY)))
    else $error("Result length exceeds the capacity.");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && op_status != plil_pkg::ST_OK) |-> (last_item && entry_value == '0))
    else $error("Error result is not a single zero-valued transfer.");

  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid)
    else $error("Back end took a command from an empty queue.");

endmodule
